FILE: rtl/dfs_spf_pkg.sv
// dfs_spf_pkg: shared types and constants for the depth-first path finder
// used by dfs_spf_scan and dfs_simple_path_finder; no other dependencies
`timescale 1ns / 1ps

package dfs_spf_pkg;

	localparam int VERTEX_W = 5;
	localparam int ROW_W    = 32;
	localparam int COUNT_W  = 6;

	// input transaction kinds
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// result of one neighbor scan
	typedef struct packed {
		logic                hit;
		logic [VERTEX_W-1:0] vtx;
	} scan_res_t;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_POP_RD   = 6'b000100,
		ST_EMIT_RD  = 6'b001000,
		ST_EMIT_OUT = 6'b010000,
		ST_NONE     = 6'b100000
	} state_t;

	function automatic logic [ROW_W-1:0] vbit(input logic [VERTEX_W-1:0] v);
		return ROW_W'(1) << v;
	endfunction

endpackage

FILE: rtl/dfs_spf_ram.sv
// dfs_spf_ram: generic single-write, single-read ram with registered read data
// standalone, no package dependency
`timescale 1ns / 1ps

module dfs_spf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/dfs_spf_scan.sv
// dfs_spf_scan: finds the lowest unvisited in-range neighbor at or above a start position
// depends on dfs_spf_pkg
`timescale 1ns / 1ps

module dfs_spf_scan
	import dfs_spf_pkg::*;
(
	input  logic [ROW_W-1:0]   row,
	input  logic [ROW_W-1:0]   visited,
	input  logic [ROW_W-1:0]   limit,
	input  logic [COUNT_W-1:0] start,
	output scan_res_t          res
);

	logic [ROW_W-1:0] cand;

	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			cand[j] = row[j] && !visited[j] && limit[j] && (COUNT_W'(j) >= start);
		end
	end

	// priority encoder, lowest index wins
	always_comb begin
		res.hit = |cand;
		res.vtx = '0;
		for (int j = ROW_W - 1; j >= 0; j--) begin
			if (cand[j]) begin
				res.vtx = VERTEX_W'(j);
			end
		end
	end

endmodule

FILE: rtl/dfs_simple_path_finder.sv
// dfs_simple_path_finder: depth-first simple path search over a directed graph
// Input channel (in_valid/in_ready): mode 0 stores row_bits as the adjacency row of
// row_index, no result. Mode 1 runs a query from source to target.
// A query returns the path vertices in order from the source on the output channel
// (out_valid/out_ready), found high, last on the final one; with no path, or with
// source or target outside vertex_count, it returns one result: vertex 0, found 0, last 1.
// cfg_valid/cfg_ready/cfg_data writes vertex_count; write it only while idle.
// One priority encoder handles the stack steps; a pop costs a stack read plus an
// adjacency read, each memory having one read port.
// in_ready is low from query accept until its last result is in the output register.
// The output register holds a result while out_ready is low; the search stalls on it.
// Reset: vertex_count returns to 32, control clears; adjacency rows must be loaded
// before a query reaches them.
// depends on dfs_spf_pkg, dfs_spf_ram, dfs_spf_scan
`timescale 1ns / 1ps

module dfs_simple_path_finder
	import dfs_spf_pkg::*;
#(
	parameter int MAX_VERTICES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [VERTEX_W-1:0] row_index,
	input  logic [ROW_W-1:0]    row_bits,
	input  logic [VERTEX_W-1:0] source,
	input  logic [VERTEX_W-1:0] target,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VERTEX_W-1:0] vertex,
	output logic                found,
	output logic                last
);

	localparam int ROWS = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
	localparam int RAW  = $clog2(ROWS);
	localparam int SAW  = $clog2(MAX_VERTICES);
	localparam int DW   = $clog2(MAX_VERTICES + 1);

	state_t              state_q, state_d;
	logic [COUNT_W-1:0]  vcount_q;
	logic [VERTEX_W-1:0] tgt_q, tgt_d;
	logic [VERTEX_W-1:0] u_q, u_d;
	logic [COUNT_W-1:0]  start_q, start_d;
	logic [DW-1:0]       depth_q, depth_d;
	logic [DW-1:0]       emit_q, emit_d;
	logic [ROW_W-1:0]    visited_q, visited_d;

	logic                out_valid_q;
	logic [VERTEX_W-1:0] vertex_q;
	logic                found_q;
	logic                last_q;
	logic                out_load;
	logic [VERTEX_W-1:0] out_vertex;
	logic                out_found;
	logic                out_last;
	logic                out_free;

	logic [ROW_W-1:0]    limit;
	scan_res_t           scan;

	logic                adj_we;
	logic                adj_re;
	logic [RAW-1:0]      adj_raddr;
	logic [ROW_W-1:0]    adj_rdata;
	logic                stk_we;
	logic [SAW-1:0]      stk_waddr;
	logic [VERTEX_W-1:0] stk_wdata;
	logic                stk_re;
	logic [SAW-1:0]      stk_raddr;
	logic [VERTEX_W-1:0] stk_rdata;
	logic [DW-1:0]       depth_m1;
	logic [DW-1:0]       depth_m2;
	logic [DW-1:0]       emit_nx;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign depth_m1  = depth_q - DW'(1);
	assign depth_m2  = depth_q - DW'(2);
	assign emit_nx   = emit_q + DW'(1);

	// vertices below both the register value and the storage size
	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			limit[j] = (COUNT_W'(j) < vcount_q) && (j < MAX_VERTICES);
		end
	end

	assign adj_we = in_valid && in_ready && (mode == MODE_LOAD)
		&& ({1'b0, row_index} < COUNT_W'(ROWS));

	dfs_spf_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_adj_ram (
		.clk  (clk),
		.we   (adj_we),
		.waddr(row_index[RAW-1:0]),
		.wdata(row_bits),
		.re   (adj_re),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	dfs_spf_ram #(
		.WIDTH(VERTEX_W),
		.DEPTH(MAX_VERTICES)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	dfs_spf_scan u_scan (
		.row    (adj_rdata),
		.visited(visited_q),
		.limit  (limit),
		.start  (start_q),
		.res    (scan)
	);

	always_comb begin
		state_d    = state_q;
		tgt_d      = tgt_q;
		u_d        = u_q;
		start_d    = start_q;
		depth_d    = depth_q;
		emit_d     = emit_q;
		visited_d  = visited_q;
		adj_re     = 1'b0;
		adj_raddr  = u_q[RAW-1:0];
		stk_we     = 1'b0;
		stk_waddr  = depth_q[SAW-1:0];
		stk_wdata  = scan.vtx;
		stk_re     = 1'b0;
		stk_raddr  = emit_q[SAW-1:0];
		out_load   = 1'b0;
		out_vertex = '0;
		out_found  = 1'b0;
		out_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (mode == MODE_QUERY)) begin
					tgt_d     = target;
					depth_d   = '0;
					visited_d = '0;
					if (!limit[source] || !limit[target]) begin
						state_d = ST_NONE;
					end else begin
						stk_we    = 1'b1;
						stk_waddr = '0;
						stk_wdata = source;
						depth_d   = DW'(1);
						visited_d = vbit(source);
						u_d       = source;
						start_d   = '0;
						if (source == target) begin
							emit_d  = '0;
							state_d = ST_EMIT_RD;
						end else begin
							adj_re    = 1'b1;
							adj_raddr = source[RAW-1:0];
							state_d   = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				if (scan.hit && (depth_q < DW'(MAX_VERTICES))) begin
					// push the neighbor
					stk_we    = 1'b1;
					depth_d   = depth_q + DW'(1);
					visited_d = visited_q | vbit(scan.vtx);
					u_d       = scan.vtx;
					start_d   = '0;
					if (scan.vtx == tgt_q) begin
						emit_d  = '0;
						state_d = ST_EMIT_RD;
					end else begin
						adj_re    = 1'b1;
						adj_raddr = scan.vtx[RAW-1:0];
					end
				end else begin
					// pop, parent resumes after this vertex
					depth_d = depth_m1;
					start_d = {1'b0, u_q} + COUNT_W'(1);
					if (depth_q == DW'(1)) begin
						state_d = ST_NONE;
					end else begin
						stk_re    = 1'b1;
						stk_raddr = depth_m2[SAW-1:0];
						state_d   = ST_POP_RD;
					end
				end
			end
			ST_POP_RD: begin
				u_d       = stk_rdata;
				adj_re    = 1'b1;
				adj_raddr = stk_rdata[RAW-1:0];
				state_d   = ST_SCAN;
			end
			ST_EMIT_RD: begin
				stk_re    = 1'b1;
				stk_raddr = emit_q[SAW-1:0];
				state_d   = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_vertex = stk_rdata;
					out_found  = 1'b1;
					out_last   = (emit_nx == depth_q);
					emit_d     = emit_nx;
					state_d    = (emit_nx == depth_q) ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_NONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcount_q    <= COUNT_W'(32);
			depth_q     <= '0;
			emit_q      <= '0;
			visited_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			depth_q   <= depth_d;
			emit_q    <= emit_d;
			visited_q <= visited_d;
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tgt_q   <= tgt_d;
		u_q     <= u_d;
		start_q <= start_d;
		if (out_load) begin
			vertex_q <= out_vertex;
			found_q  <= out_found;
			last_q   <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex    = vertex_q;
	assign found     = found_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_VERTICES))
		else $error("stack depth beyond capacity");

	a_nopath_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (vertex == '0) && last)
		else $error("no-path result malformed");

	a_top_visited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> visited_q[u_q])
		else $error("top of stack not marked visited");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_QUERY) |=> !in_ready)
		else $error("ready while query in progress");
`endif

endmodule
